// ===== design/assert_macros.svh =====
// Assertion macros for the search block RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/smf_pkg.sv =====
// Types, register codes and byte compare helpers for the substring search block.
`default_nettype none

package smf_pkg;

	localparam int BYTE_W     = 8;
	localparam int PAT_BYTES  = 16;
	localparam int PIDX_W     = 4;
	localparam int LEN_W      = 5;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 64;
	localparam int START_W    = 16;

	typedef logic [BYTE_W-1:0]                 byte_t;
	typedef logic [PAT_BYTES-1:0][BYTE_W-1:0]  pat_t;
	typedef logic [LEN_W-1:0]                  len_t;
	typedef logic [CFG_IDX_W-1:0]              cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0]             cfg_data_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAT_LO    = 4'd0,
		REG_PAT_HI    = 4'd1,
		REG_PAT_LEN   = 4'd2,
		REG_CASE_SENS = 4'd3
	} cfg_reg_t;

	typedef struct packed {
		logic               found;
		logic [START_W-1:0] start;
		logic               ovf;
	} res_t;

	function automatic byte_t fold_upper(byte_t c);
		byte_t r;
		r = c;
		if (c >= 8'h61 && c <= 8'h7a) begin
			r = c - 8'h20;
		end
		return r;
	endfunction

	function automatic logic bytes_equal(byte_t a, byte_t b, logic fold);
		logic r;
		if (fold) begin
			r = (fold_upper(a) == fold_upper(b));
		end else begin
			r = (a == b);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== design/smf_ifs.sv =====
// Handshake channels of the substring search block: text in, result out, config write.
`default_nettype none

interface smf_text_if;
	import smf_pkg::*;
	logic  valid;
	logic  ready;
	byte_t text_byte;
	logic  text_last;
	modport source (output valid, output text_byte, output text_last, input ready);
	modport sink (input valid, input text_byte, input text_last, output ready);
endinterface

interface smf_result_if;
	import smf_pkg::*;
	logic               valid;
	logic               ready;
	logic               match_found;
	logic [START_W-1:0] match_start;
	logic               position_overflow;
	modport source (output valid, output match_found, output match_start,
		output position_overflow, input ready);
	modport sink (input valid, input match_found, input match_start,
		input position_overflow, output ready);
endinterface

interface smf_cfg_if;
	import smf_pkg::*;
	logic      valid;
	logic      ready;
	cfg_idx_t  index;
	cfg_data_t data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/substring_first_match.sv =====
// Top level of the streaming first-match substring search.
`default_nettype none
`include "assert_macros.svh"

// Streaming search for the first occurrence of a pattern of up to MAX_PATTERN
// bytes. Text arrives one word per cycle while text.ready is high, one byte
// each, text_last on the final byte; one result comes per text: found with its
// start index at the byte that completes the first match, or not found at the
// last byte. The block takes a byte every cycle unless stalled: a row of
// MAX_PATTERN cells shifts the recent bytes and compares all window positions
// against the pattern in the same cycle, the AND of the cell compares rippling
// down the row. A result is registered in the output register, or in a one-word
// skid stage while the output waits; input stalls only when both are full.
// Configuration writes take effect from the next byte and are always accepted.
module substring_first_match #(
	parameter int MAX_PATTERN   = 16,
	parameter int POSITION_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	smf_cfg_if.sink      cfg,
	smf_text_if.sink     text,
	smf_result_if.source result
);
	import smf_pkg::*;

	localparam int   SW   = (POSITION_BITS + 1 > START_W) ? POSITION_BITS + 1 : START_W;
	localparam len_t MAXL = len_t'(MAX_PATTERN);

	logic [CFG_DATA_W-1:0] pat_lo_q, pat_hi_q;
	len_t                  len_q;
	logic                  case_sens_q;

	logic [POSITION_BITS-1:0] bytes_seen_q;
	logic                     answered_q;
	logic                     overflowed_q;

	res_t out_q, skid_q;
	logic out_valid_q, skid_valid_q;

	pat_t  pattern;
	len_t  len_eff;
	logic  in_fire, out_fire;
	logic  sat, ovf_now, enough, hit, emit;
	logic [POSITION_BITS:0] count_p1;
	logic [SW-1:0]          start_w;
	res_t  res_new;

	byte_t bytes_w [0:MAX_PATTERN-1];
	logic  match_w [0:MAX_PATTERN];

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q    <= '0;
			pat_hi_q    <= '0;
			len_q       <= '0;
			case_sens_q <= 1'b1;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_PAT_LO:    pat_lo_q    <= cfg.data;
				REG_PAT_HI:    pat_hi_q    <= cfg.data;
				REG_PAT_LEN:   len_q       <= cfg.data[LEN_W-1:0];
				REG_CASE_SENS: case_sens_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	assign pattern = pat_t'({pat_hi_q, pat_lo_q});
	assign len_eff = (len_q > MAXL) ? MAXL : len_q;

	// cell row
	assign in_fire     = text.valid & text.ready;
	assign bytes_w[0]  = text.text_byte;
	assign match_w[0]  = 1'b1;

	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		if (k < MAX_PATTERN - 1) begin : g_mid
			smf_cell #(.INDEX(k), .STORE(1'b1)) u_cell (
				.clk       (clk),
				.shift     (in_fire & ~text.text_last),
				.in_byte   (bytes_w[k]),
				.pattern   (pattern),
				.len_eff   (len_eff),
				.fold      (~case_sens_q),
				.match_in  (match_w[k]),
				.match_out (match_w[k+1]),
				.byte_out  (bytes_w[k+1])
			);
		end else begin : g_end
			smf_cell #(.INDEX(k), .STORE(1'b0)) u_cell (
				.clk       (clk),
				.shift     (1'b0),
				.in_byte   (bytes_w[k]),
				.pattern   (pattern),
				.len_eff   (len_eff),
				.fold      (~case_sens_q),
				.match_in  (match_w[k]),
				.match_out (match_w[k+1]),
				.byte_out  ()
			);
		end
	end

	// per-text control
	assign sat      = &bytes_seen_q;
	assign ovf_now  = overflowed_q | sat;
	assign count_p1 = {1'b0, bytes_seen_q} + {{POSITION_BITS{1'b0}}, 1'b1};
	assign enough   = count_p1 >= (POSITION_BITS+1)'(len_eff);
	assign hit      = ~answered_q & (len_eff != '0) & enough & match_w[MAX_PATTERN];
	assign emit     = in_fire & (hit | (text.text_last & ~answered_q));
	assign start_w  = SW'(bytes_seen_q) + SW'(1) - SW'(len_eff);

	always_comb begin
		res_new.found = hit;
		res_new.start = hit ? start_w[START_W-1:0] : '0;
		res_new.ovf   = ovf_now;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_seen_q <= '0;
			answered_q   <= 1'b0;
			overflowed_q <= 1'b0;
		end else if (in_fire) begin
			if (text.text_last) begin
				bytes_seen_q <= '0;
				answered_q   <= 1'b0;
				overflowed_q <= 1'b0;
			end else begin
				// hold the counter at its limit
				bytes_seen_q <= sat ? bytes_seen_q : count_p1[POSITION_BITS-1:0];
				answered_q   <= answered_q | hit;
				overflowed_q <= ovf_now;
			end
		end
	end

	// output register with skid stage
	assign out_fire   = out_valid_q & result.ready;
	assign text.ready = ~skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (emit) begin
			if (!out_valid_q || out_fire) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_fire) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (!out_valid_q || out_fire) begin
				out_q <= res_new;
			end else begin
				skid_q <= res_new;
			end
		end else if (out_fire && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	assign result.valid             = out_valid_q;
	assign result.match_found       = out_q.found;
	assign result.match_start       = out_q.start;
	assign result.position_overflow = out_q.ovf;

	`ASSERT_SAME(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q)
	`ASSERT_NEXT(a_end_gives_word, clk, arst_n, in_fire && text.text_last && !answered_q, out_valid_q)
	`ASSERT_SAME(a_one_per_text, clk, arst_n, in_fire && answered_q, !hit)
	`ASSERT_SAME(a_fresh_text_clear, clk, arst_n, bytes_seen_q == '0, !answered_q && !overflowed_q)

endmodule

`default_nettype wire

// ===== design/smf_cell.sv =====
// One window cell: holds a recent byte when STORE is set, compares the byte at its distance to the pattern.
`default_nettype none

module smf_cell #(
	parameter int INDEX = 0,
	parameter bit STORE = 1'b1
) (
	input  logic          clk,
	input  logic          shift,
	input  smf_pkg::byte_t in_byte,
	input  smf_pkg::pat_t  pattern,
	input  smf_pkg::len_t  len_eff,
	input  logic          fold,
	input  logic          match_in,
	output logic          match_out,
	output smf_pkg::byte_t byte_out
);
	import smf_pkg::*;

	localparam len_t K = len_t'(INDEX);

	len_t            sel;
	logic [PIDX_W-1:0] pidx;
	logic            active;
	logic            eq;

	// distance K from the newest byte lines up with pattern byte len-1-K
	assign sel    = len_eff - K - len_t'(1);
	assign pidx   = sel[PIDX_W-1:0];
	assign active = (K < len_eff);
	assign eq     = bytes_equal(in_byte, pattern[pidx], fold);
	assign match_out = match_in & (~active | eq);

	if (STORE) begin : g_store
		byte_t byte_q;
		always_ff @(posedge clk) begin
			if (shift) begin
				byte_q <= in_byte;
			end
		end
		assign byte_out = byte_q;
	end else begin : g_nostore
		assign byte_out = '0;
	end

endmodule

`default_nettype wire
